>>> rtl/rrb_pkg.sv
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared widths, operation codes and controller/datapath interface structs
// for the resume retransmit buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package rrb_pkg;

    localparam int POS_W  = 48;
    localparam int LEN_W  = 32;
    localparam int SID_W  = 31;
    localparam int OP_W   = 3;
    localparam int TYPE_W = 6;
    localparam int CAP_W  = 32;

    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 184;

    localparam logic [CAP_W-1:0] CAP_RESET = 32'd1048576;

    // Replay emits at most this many frames per request
    localparam int REPLAY_LIMIT = 64;
    localparam int RN_W         = 6;

    // Tracked frame types: requests, credit requests, cancel, error, payload
    localparam logic [TYPE_W-1:0] TYPE_TRACK_LO = 6'd4;
    localparam logic [TYPE_W-1:0] TYPE_TRACK_HI = 6'd11;

    localparam logic [OP_W-1:0] OP_RECV   = 3'd0;
    localparam logic [OP_W-1:0] OP_SENT   = 3'd1;
    localparam logic [OP_W-1:0] OP_RESET  = 3'd2;
    localparam logic [OP_W-1:0] OP_QPOS   = 3'd3;
    localparam logic [OP_W-1:0] OP_QSTR   = 3'd4;
    localparam logic [OP_W-1:0] OP_REPLAY = 3'd5;

    typedef struct packed {
        logic load;
        logic recv_add;
        logic k_clr;
        logic k_one;
        logic k_inc;
        logic sidx_clr;
        logic sidx_inc;
        logic sweep_sent;
        logic sweep_pe;
        logic sweep_nt;
        logic sweep_chk;
        logic lk_init;
        logic lk_chk;
        logic lk_store;
        logic q_stream;
        logic ovf_fin;
        logic drop;
        logic push;
        logic avail_set;
        logic rp_init;
        logic rp_step;
        logic e_sent;
        logic e_frd;
        logic rp_adv;
        logic out_gen;
        logic out_rp;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic tracked;
        logic oversize;
        logic has_sid;
        logic p_eq_sent;
        logic p_le_trim;
        logic sent_gt_trim;
        logic k_lt_count;
        logic k1_lt_count;
        logic frd_lt_pe;
        logic frd_lt_q;
        logic frd_eq_q;
        logic ev_need;
        logic sidx_last;
        logic lastf;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/rrb_dp.sv
// ----------------------------------------------------------------------------
// rrb_dp
// Datapath: positions, frame start FIFO memory, stream table memory,
// comparators and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrb_dp
    import rrb_pkg::*;
#(
    parameter int FRAME_SLOTS  = 64,
    parameter int STREAM_SLOTS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CAP_W-1:0]      cfg_wdata,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [OP_W-1:0]       s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tlast,
    input  wire cmd_t                  cmd,
    output sts_t                       sts
);

    localparam int HW = $clog2(FRAME_SLOTS);
    localparam int CW = $clog2(FRAME_SLOTS + 1);
    localparam int SW = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
    localparam logic [HW:0]   FS_EXT   = (HW+1)'(FRAME_SLOTS);
    localparam logic [CW-1:0] FS_CNT   = CW'(FRAME_SLOTS);
    localparam logic [SW-1:0] SIDX_MAX = SW'(STREAM_SLOTS - 1);
    localparam logic [RN_W-1:0] RN_MAX = RN_W'(REPLAY_LIMIT - 1);

    // Input item
    logic [OP_W-1:0]   op_reg;
    logic [TYPE_W-1:0] type_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              hsid_reg;
    logic [SID_W-1:0]  sid_reg;
    logic [POS_W-1:0]  qp_reg;

    // Block state
    logic [CAP_W-1:0]  cap_reg;
    logic [POS_W-1:0]  sent_reg;
    logic [POS_W-1:0]  recv_reg;
    logic [POS_W-1:0]  trim_reg;
    logic [LEN_W:0]    cached_reg;
    logic [HW-1:0]     head_reg;
    logic [CW-1:0]     count_reg;

    // Walk state
    logic [CW-1:0]     k_reg;
    logic [SW-1:0]     sidx_reg;
    logic [POS_W-1:0]  frd_reg;
    logic [SID_W-1:0]  srd_key;
    logic [POS_W-1:0]  srd_end;
    logic [POS_W-1:0]  sweep_reg;
    logic              avail_reg;
    logic              ovf_reg;
    logic              hit_reg;
    logic [SW-1:0]     hit_idx_reg;
    logic [POS_W-1:0]  hit_end_reg;
    logic              free_reg;
    logic [SW-1:0]     free_idx_reg;
    logic [POS_W-1:0]  scur_reg;
    logic [POS_W-1:0]  e_reg;
    logic [RN_W-1:0]   n_reg;
    logic              lastf_reg;
    logic [STREAM_SLOTS-1:0] svalid_reg;

    // Output register
    logic              out_valid_reg;
    logic              o_avail_reg;
    logic [POS_W-1:0]  o_start_reg;
    logic [LEN_W-1:0]  o_len_reg;
    logic              o_last_reg;
    logic [POS_W-1:0]  o_sent_reg;
    logic [POS_W-1:0]  o_recv_reg;
    logic              o_ovf_reg;

    logic [POS_W-1:0]  fmem [FRAME_SLOTS];
    logic [SID_W+POS_W-1:0] smem [STREAM_SLOTS];

    function automatic logic [HW-1:0] slot_of(input logic [HW-1:0] h,
                                             input logic [CW-1:0] off);
        logic [HW:0] sum;
        sum = {1'b0, h} + (HW+1)'(off);
        if (sum >= FS_EXT)
            sum = sum - FS_EXT;
        return sum[HW-1:0];
    endfunction

    logic [HW-1:0]    rd_slot;
    logic [HW-1:0]    wr_slot;
    logic [POS_W-1:0] p_eff;
    logic [POS_W-1:0] nt;
    logic [POS_W-1:0] drop_d;
    logic [CW-1:0]    count_left;
    logic             s_valid;
    logic [LEN_W+1:0] need_bytes;
    logic [POS_W-1:0] rp_len;

    assign rd_slot    = slot_of(head_reg, k_reg);
    assign wr_slot    = slot_of(head_reg, count_reg);
    assign p_eff      = (qp_reg > sent_reg) ? sent_reg : qp_reg;
    assign nt         = (count_reg > CW'(1)) ? frd_reg : sent_reg;
    assign drop_d     = frd_reg - trim_reg;
    assign count_left = count_reg - k_reg;
    assign s_valid    = svalid_reg[sidx_reg];
    assign need_bytes = {1'b0, cached_reg} + (LEN_W+2)'(len_reg);
    assign rp_len     = e_reg - scur_reg;

    // Status toward the controller
    always_comb
    begin
        sts.op           = op_reg;
        sts.tracked      = (type_reg >= TYPE_TRACK_LO) && (type_reg <= TYPE_TRACK_HI);
        sts.oversize     = len_reg > cap_reg;
        sts.has_sid      = hsid_reg;
        sts.p_eq_sent    = qp_reg == sent_reg;
        sts.p_le_trim    = qp_reg <= trim_reg;
        sts.sent_gt_trim = sent_reg > trim_reg;
        sts.k_lt_count   = k_reg < count_reg;
        sts.k1_lt_count  = ((CW+1)'(k_reg) + (CW+1)'(1)) < (CW+1)'(count_reg);
        sts.frd_lt_pe    = frd_reg < sweep_reg;
        sts.frd_lt_q     = frd_reg < qp_reg;
        sts.frd_eq_q     = frd_reg == qp_reg;
        sts.ev_need      = (count_reg != '0) &&
                           ((need_bytes > (LEN_W+2)'(cap_reg)) || (count_reg >= FS_CNT));
        sts.sidx_last    = sidx_reg == SIDX_MAX;
        sts.lastf        = lastf_reg;
        sts.out_free     = !out_valid_reg || m_tready;
    end

    // Capture input and configuration
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg <= s_tdata[5:0];
            len_reg  <= s_tdata[37:6];
            hsid_reg <= s_tdata[38];
            sid_reg  <= s_tdata[69:39];
            qp_reg   <= s_tdata[117:70];
            op_reg   <= s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_we)
            cap_reg <= cfg_wdata;
    end

    // Positions and FIFO bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg   <= '0;
            recv_reg   <= '0;
            trim_reg   <= '0;
            cached_reg <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cmd.recv_add)
                recv_reg <= recv_reg + POS_W'(len_reg);
            if (cmd.ovf_fin)
            begin
                if (sent_reg > trim_reg)
                    trim_reg <= sent_reg;
                head_reg   <= '0;
                count_reg  <= '0;
                cached_reg <= '0;
                sent_reg   <= sent_reg + POS_W'(len_reg);
            end
            else if (cmd.drop)
            begin
                head_reg  <= slot_of(head_reg, k_reg);
                count_reg <= count_left;
                if (count_left == '0)
                    cached_reg <= '0;
                else if (drop_d > POS_W'(cached_reg))
                    cached_reg <= '0;
                else
                    cached_reg <= cached_reg - drop_d[LEN_W:0];
                trim_reg <= sweep_reg;
            end
            else if (cmd.push)
            begin
                count_reg  <= count_reg + CW'(1);
                cached_reg <= cached_reg + (LEN_W+1)'(len_reg);
                sent_reg   <= sent_reg + POS_W'(len_reg);
            end
        end
    end

    // Frame start memory: write on push, read at the walk index
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            fmem[wr_slot] <= sent_reg;
        frd_reg <= fmem[rd_slot];
    end

    // Stream table memory
    always_ff @(posedge clk)
    begin
        if (cmd.lk_store && hit_reg)
            smem[hit_idx_reg] <= {sid_reg, sent_reg};
        else if (cmd.lk_store && free_reg)
            smem[free_idx_reg] <= {sid_reg, sent_reg};
        {srd_key, srd_end} <= smem[sidx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            svalid_reg <= '0;
        else if (cmd.sweep_chk && s_valid && (srd_end <= sweep_reg))
            svalid_reg[sidx_reg] <= 1'b0;
        else if (cmd.lk_store && !hit_reg && free_reg)
            svalid_reg[free_idx_reg] <= 1'b1;
    end

    // Walk counters and search results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            sidx_reg  <= '0;
            avail_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            n_reg     <= '0;
            lastf_reg <= 1'b0;
        end
        else
        begin
            if (cmd.k_clr)
                k_reg <= '0;
            else if (cmd.k_one)
                k_reg <= CW'(1);
            else if (cmd.k_inc)
                k_reg <= k_reg + CW'(1);

            if (cmd.sidx_clr)
                sidx_reg <= '0;
            else if (cmd.sidx_inc)
                sidx_reg <= sidx_reg + SW'(1);

            if (cmd.load)
            begin
                avail_reg <= 1'b0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.avail_set)
                avail_reg <= 1'b1;
            else if (cmd.q_stream)
                avail_reg <= hit_reg ? (hit_end_reg <= qp_reg) : (trim_reg >= qp_reg);
            else if (cmd.lk_store && !hit_reg && !free_reg)
                ovf_reg <= 1'b1;

            if (cmd.lk_init)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else if (cmd.lk_chk)
            begin
                if (s_valid && (srd_key == sid_reg) && !hit_reg)
                    hit_reg <= 1'b1;
                if (!s_valid && !free_reg)
                    free_reg <= 1'b1;
            end

            if (cmd.rp_init)
                n_reg <= '0;
            else if (cmd.rp_adv)
                n_reg <= n_reg + RN_W'(1);

            if (cmd.rp_step)
                lastf_reg <= !sts.k1_lt_count || (n_reg == RN_MAX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_sent)
            sweep_reg <= sent_reg;
        else if (cmd.sweep_pe)
            sweep_reg <= p_eff;
        else if (cmd.sweep_nt)
            sweep_reg <= nt;

        if (cmd.lk_chk && s_valid && (srd_key == sid_reg) && !hit_reg)
        begin
            hit_idx_reg <= sidx_reg;
            hit_end_reg <= srd_end;
        end
        if (cmd.lk_chk && !s_valid && !free_reg)
            free_idx_reg <= sidx_reg;

        if (cmd.rp_init)
            scur_reg <= frd_reg;
        else if (cmd.rp_adv)
            scur_reg <= e_reg;

        if (cmd.e_sent)
            e_reg <= sent_reg;
        else if (cmd.e_frd)
            e_reg <= frd_reg;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_gen || cmd.out_rp)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_gen)
        begin
            o_avail_reg <= avail_reg;
            o_start_reg <= '0;
            o_len_reg   <= '0;
            o_last_reg  <= 1'b1;
            o_ovf_reg   <= ovf_reg;
            o_sent_reg  <= sent_reg;
            o_recv_reg  <= recv_reg;
        end
        else if (cmd.out_rp)
        begin
            o_avail_reg <= 1'b1;
            o_start_reg <= scur_reg;
            o_len_reg   <= rp_len[LEN_W-1:0];
            o_last_reg  <= lastf_reg;
            o_ovf_reg   <= 1'b0;
            o_sent_reg  <= sent_reg;
            o_recv_reg  <= recv_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {6'd0, o_ovf_reg, o_recv_reg, o_sent_reg, o_len_reg,
                       o_start_reg, o_avail_reg};

    // Checks on FIFO bookkeeping
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FS_CNT)
        else $error("frame count exceeds slots");

    a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (cached_reg == '0))
        else $error("empty FIFO holds bytes");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not advance count");

endmodule

`default_nettype wire

>>> rtl/rrb_ctrl.sv
// ----------------------------------------------------------------------------
// rrb_ctrl
// Sequencer: decodes each transaction and steps the datapath through
// evictions, stream table walks, FIFO scans and replay.
// ----------------------------------------------------------------------------
`default_nettype none

module rrb_ctrl
    import rrb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_DISP    = 5'd1;
    localparam logic [4:0] ST_SW_WAIT = 5'd2;
    localparam logic [4:0] ST_SW_CHK  = 5'd3;
    localparam logic [4:0] ST_OVF_FIN = 5'd4;
    localparam logic [4:0] ST_RS_WAIT = 5'd5;
    localparam logic [4:0] ST_RS_CHK  = 5'd6;
    localparam logic [4:0] ST_EV_CHK  = 5'd7;
    localparam logic [4:0] ST_EV_WAIT = 5'd8;
    localparam logic [4:0] ST_EV_NT   = 5'd9;
    localparam logic [4:0] ST_EV_DROP = 5'd10;
    localparam logic [4:0] ST_PUSH    = 5'd11;
    localparam logic [4:0] ST_LK_WAIT = 5'd12;
    localparam logic [4:0] ST_LK_CHK  = 5'd13;
    localparam logic [4:0] ST_LK_DONE = 5'd14;
    localparam logic [4:0] ST_QP_WAIT = 5'd15;
    localparam logic [4:0] ST_QP_CHK  = 5'd16;
    localparam logic [4:0] ST_RP_WAIT = 5'd17;
    localparam logic [4:0] ST_RP_CHK  = 5'd18;
    localparam logic [4:0] ST_RP_STEP = 5'd19;
    localparam logic [4:0] ST_RP_RDW  = 5'd20;
    localparam logic [4:0] ST_RP_GET  = 5'd21;
    localparam logic [4:0] ST_RP_OUT  = 5'd22;
    localparam logic [4:0] ST_EMIT    = 5'd23;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign s_tready = state_reg == ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                state_next = ST_EMIT;
                case (sts.op)
                    OP_RECV:
                    begin
                        cmd.recv_add = sts.tracked;
                    end
                    OP_SENT:
                    begin
                        if (sts.tracked && sts.oversize)
                        begin
                            if (sts.sent_gt_trim)
                            begin
                                cmd.sweep_sent = 1'b1;
                                cmd.sidx_clr   = 1'b1;
                                state_next     = ST_SW_WAIT;
                            end
                            else
                                state_next = ST_OVF_FIN;
                        end
                        else if (sts.tracked)
                            state_next = ST_EV_CHK;
                    end
                    OP_RESET:
                    begin
                        if (!sts.p_le_trim)
                        begin
                            cmd.sweep_pe = 1'b1;
                            cmd.sidx_clr = 1'b1;
                            cmd.k_clr    = 1'b1;
                            state_next   = ST_SW_WAIT;
                        end
                    end
                    OP_QPOS:
                    begin
                        if (sts.p_eq_sent)
                            cmd.avail_set = 1'b1;
                        else
                        begin
                            cmd.k_clr  = 1'b1;
                            state_next = ST_QP_WAIT;
                        end
                    end
                    OP_QSTR:
                    begin
                        cmd.lk_init  = 1'b1;
                        cmd.sidx_clr = 1'b1;
                        state_next   = ST_LK_WAIT;
                    end
                    OP_REPLAY:
                    begin
                        if (sts.p_eq_sent)
                            cmd.avail_set = 1'b1;
                        else
                        begin
                            cmd.k_clr  = 1'b1;
                            state_next = ST_RP_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_SW_WAIT:
            begin
                state_next = ST_SW_CHK;
            end
            ST_SW_CHK:
            begin
                cmd.sweep_chk = 1'b1;
                if (!sts.sidx_last)
                begin
                    cmd.sidx_inc = 1'b1;
                    state_next   = ST_SW_WAIT;
                end
                else if (sts.op == OP_SENT && sts.oversize)
                    state_next = ST_OVF_FIN;
                else if (sts.op == OP_SENT)
                    state_next = ST_EV_DROP;
                else
                    state_next = ST_RS_CHK;
            end
            ST_OVF_FIN:
            begin
                cmd.ovf_fin = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_RS_WAIT:
            begin
                state_next = ST_RS_CHK;
            end
            ST_RS_CHK:
            begin
                if (sts.k_lt_count && sts.frd_lt_pe)
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_RS_WAIT;
                end
                else
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EV_CHK:
            begin
                if (sts.ev_need)
                begin
                    cmd.k_one  = 1'b1;
                    state_next = ST_EV_WAIT;
                end
                else
                    state_next = ST_PUSH;
            end
            ST_EV_WAIT:
            begin
                state_next = ST_EV_NT;
            end
            ST_EV_NT:
            begin
                cmd.sweep_nt = 1'b1;
                cmd.sidx_clr = 1'b1;
                state_next   = ST_SW_WAIT;
            end
            ST_EV_DROP:
            begin
                cmd.drop   = 1'b1;
                state_next = ST_EV_CHK;
            end
            ST_PUSH:
            begin
                cmd.push = 1'b1;
                if (sts.has_sid)
                begin
                    cmd.lk_init  = 1'b1;
                    cmd.sidx_clr = 1'b1;
                    state_next   = ST_LK_WAIT;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_LK_WAIT:
            begin
                state_next = ST_LK_CHK;
            end
            ST_LK_CHK:
            begin
                cmd.lk_chk = 1'b1;
                if (sts.sidx_last)
                    state_next = ST_LK_DONE;
                else
                begin
                    cmd.sidx_inc = 1'b1;
                    state_next   = ST_LK_WAIT;
                end
            end
            ST_LK_DONE:
            begin
                if (sts.op == OP_SENT)
                    cmd.lk_store = 1'b1;
                else
                    cmd.q_stream = 1'b1;
                state_next = ST_EMIT;
            end
            ST_QP_WAIT:
            begin
                state_next = ST_QP_CHK;
            end
            ST_QP_CHK:
            begin
                if (!sts.k_lt_count)
                    state_next = ST_EMIT;
                else if (sts.frd_eq_q)
                begin
                    cmd.avail_set = 1'b1;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_QP_WAIT;
                end
            end
            ST_RP_WAIT:
            begin
                state_next = ST_RP_CHK;
            end
            ST_RP_CHK:
            begin
                if (sts.k_lt_count && sts.frd_lt_q)
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_RP_WAIT;
                end
                else if (!sts.k_lt_count || !sts.frd_eq_q)
                    state_next = ST_EMIT;
                else
                begin
                    cmd.rp_init = 1'b1;
                    state_next  = ST_RP_STEP;
                end
            end
            ST_RP_STEP:
            begin
                cmd.rp_step = 1'b1;
                if (sts.k1_lt_count)
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_RP_RDW;
                end
                else
                begin
                    cmd.e_sent = 1'b1;
                    state_next = ST_RP_OUT;
                end
            end
            ST_RP_RDW:
            begin
                state_next = ST_RP_GET;
            end
            ST_RP_GET:
            begin
                cmd.e_frd  = 1'b1;
                state_next = ST_RP_OUT;
            end
            ST_RP_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_rp = 1'b1;
                    if (sts.lastf)
                        state_next = ST_IDLE;
                    else
                    begin
                        cmd.rp_adv = 1'b1;
                        state_next = ST_RP_STEP;
                    end
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_gen = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer checks
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == ST_IDLE))
        else $error("item taken while busy");

    a_one_output: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.out_gen && cmd.out_rp))
        else $error("two results loaded at once");

    a_disp_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_DISP))
        else $error("accepted item not dispatched");

endmodule

`default_nettype wire

>>> rtl/resume_retransmit_buffer_unit.sv
// ----------------------------------------------------------------------------
// resume_retransmit_buffer_unit
// Byte-bounded retransmit buffer: tracks sent/received positions, caches
// frame starts for resumption, answers resume queries and replays frames.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields
//  s_*       in   tuser: operation; tdata: frame item
//  m_*       out  tdata: result fields; tlast: final result of the item
//  cfg_*     in   capacity_bytes write
//
//  One item at a time; s_tready is high only between items.
//  Each eviction includes one stream table walk. Position queries and
//  replay scans step through the cached frames one at a time; replay then
//  emits one result per frame. Output stalls hold the walk. Stream valid
//  bits clear at reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module resume_retransmit_buffer_unit
    import rrb_pkg::*;
#(
    parameter int FRAME_SLOTS  = 64,
    parameter int STREAM_SLOTS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CAP_W-1:0]      cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // frame_type[5:0], frame_length[37:6], has_stream_id[38],
    // stream_id[69:39], query_position[117:70], zero pad
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // operation[2:0]
    input  wire logic [OP_W-1:0]       s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // available[0], replay_start[48:1], replay_length[80:49],
    // sent_position[128:81], received_position[176:129],
    // stream_overflow[177], zero pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tlast
);

    cmd_t cmd;
    sts_t sts;

    rrb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rrb_dp #(
        .FRAME_SLOTS  (FRAME_SLOTS),
        .STREAM_SLOTS (STREAM_SLOTS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
